// ===== rtl/mccs_pkg.sv =====
// Package for the minimum coin change search unit.
// Holds field widths, register indexes, fixed coin values and the result beat type.
// No dependencies.
package mccs_pkg;

  localparam int COIN_W       = 10;
  localparam int FIELD_W      = 10;
  localparam int SLOT_MAX     = 8;
  localparam int SLOT_W       = 3;
  localparam int REPORT_SLOTS = 5;
  localparam int NUM_CFG_REGS = 5;
  localparam int CFG_ADDR_W   = 5;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 32;

  localparam logic [FIELD_W-1:0] FIELD_MAX = 10'd1023;

  typedef logic [COIN_W-1:0] coin_t;

  // Reset values of the configurable slots, then the fixed extra denominations.
  localparam coin_t COIN_RESET [SLOT_MAX] = '{
    10'd1, 10'd5, 10'd10, 10'd25, 10'd50, 10'd100, 10'd200, 10'd500
  };

  // Register indexes (byte address / 4)
  localparam logic [CFG_IDX_W-1:0] REG_COIN_0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COIN_1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COIN_2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COIN_3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COIN_4 = 3'd4;

  typedef struct packed {
    logic               solution_found;
    logic [FIELD_W-1:0] total_coins;
    logic [FIELD_W-1:0] count_first;
    logic [FIELD_W-1:0] count_second;
    logic [FIELD_W-1:0] count_third;
    logic [FIELD_W-1:0] count_fourth;
    logic [FIELD_W-1:0] count_fifth;
  } mccs_result_t;

endpackage

// ===== rtl/mccs_in_if.sv =====
// Input channel of the minimum coin change search unit: one amount per beat.
// Valid/ready handshake; no package dependency.
interface mccs_in_if #(
  parameter int AMOUNT_WIDTH = 10
) ();
  logic                    valid;
  logic                    ready;
  logic [AMOUNT_WIDTH-1:0] amount;

  modport source (output valid, output amount, input ready);
  modport sink   (input valid, input amount, output ready);
endinterface

// ===== rtl/mccs_out_if.sv =====
// Result channel of the minimum coin change search unit: one result per beat.
// Valid/ready handshake; payload type from mccs_pkg.
interface mccs_out_if import mccs_pkg::*; ();
  logic         valid;
  logic         ready;
  mccs_result_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/minimum_coin_change_search_unit.sv =====
// Sequence: a table sweep reads and writes every remainder of every denomination row, then
//   a pick-back per denomination if a solution exists, then the result is unloaded.
// Flow: one amount at a time; the single table memory and its shared compare unit serve
//   the whole search. Next beat is taken the cycle after the result is registered.
// Reset (rst_n, synchronous, active low): idle, no result pending, coin values 1,5,10,25,50.
module minimum_coin_change_search_unit import mccs_pkg::*; #(
  parameter int NUM_DENOMINATIONS = 5,
  parameter int AMOUNT_WIDTH      = 10
) (
  input  logic                  clk,
  input  logic                  rst_n,
  mccs_in_if.sink               in_ch,
  mccs_out_if.source            out_ch,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int AW        = AMOUNT_WIDTH;
  localparam int ROW_W     = (NUM_DENOMINATIONS > 1) ? $clog2(NUM_DENOMINATIONS) : 1;
  localparam int ADDR_W    = ROW_W + AW;
  localparam int MEM_DEPTH = 1 << ADDR_W;
  localparam int CMP_W     = ((AW > COIN_W) ? AW : COIN_W) + 1;
  localparam int SAT_W     = (AW > FIELD_W) ? AW : FIELD_W;

  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(NUM_DENOMINATIONS - 1);

  // Table entry: top bit flags "no way to make this remainder", low bits hold coin count.
  typedef logic [AW:0] entry_t;
  localparam entry_t NO_WAY = {1'b1, {AW{1'b0}}};

  // Sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DP_RD  = 3'd1;
  localparam logic [2:0] S_DP_WR  = 3'd2;
  localparam logic [2:0] S_TB_RD  = 3'd3;
  localparam logic [2:0] S_TB_CHK = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  logic [2:0]       state_r,     state_nxt;
  logic             out_valid_r, out_valid_nxt;
  coin_t            coin_r [NUM_CFG_REGS];
  logic [ROW_W-1:0] i_r,         i_nxt;       // current denomination slot
  logic [AW-1:0]    r_r,         r_nxt;       // remainder swept in the table pass
  logic [AW-1:0]    amount_r,    amount_nxt;
  logic [AW-1:0]    left_r,      left_nxt;    // remainder still open during pick-back
  logic [AW-1:0]    k_r,         k_nxt;       // candidate count of current slot
  logic [AW-1:0]    need_r,      need_nxt;    // coins still owed to reach the optimum
  logic             found_r,     found_nxt;
  logic [AW-1:0]    total_r,     total_nxt;
  logic [AW-1:0]    cnt_r [REPORT_SLOTS];
  logic [AW-1:0]    cnt_nxt [REPORT_SLOTS];
  mccs_result_t     res_r,       res_nxt;

  // ---------------------------------------------------------------------------
  // Coin lookup: configured slots first, fixed denominations above them
  // ---------------------------------------------------------------------------
  coin_t coin_slot [SLOT_MAX];
  coin_t cur_coin;

  always_comb begin
    for (int j = 0; j < SLOT_MAX; j++) begin
      coin_slot[j] = (j < NUM_CFG_REGS) ? coin_r[j] : COIN_RESET[j];
    end
  end

  assign cur_coin = coin_slot[SLOT_W'(i_r)];

  // Shared compare/subtract unit operands
  logic [CMP_W-1:0] coin_w, r_w, left_w;
  logic             coin_fits_r, coin_fits_left;

  assign coin_w         = CMP_W'(cur_coin);
  assign r_w            = CMP_W'(r_r);
  assign left_w         = CMP_W'(left_r);
  assign coin_fits_r    = (cur_coin != '0) && (r_w >= coin_w);
  assign coin_fits_left = (left_w >= coin_w);

  // ---------------------------------------------------------------------------
  // Table memory: row i holds the fewest coins of slots i..N-1 for each remainder.
  // Row N (no coins left) is implied: zero for remainder 0, else no way.
  // Every entry read for an amount is written earlier for that same amount.
  // ---------------------------------------------------------------------------
  entry_t              fewest_mem [MEM_DEPTH];
  logic [ADDR_W-1:0]   addr_a, addr_b, addr_w;
  logic                mem_we;
  entry_t              rd_a_q, rd_b_q;
  entry_t              best;

  // Port A: next row at the swept remainder (table pass) or open remainder (pick-back).
  // Port B: same row, one coin back.
  assign addr_a = {ROW_W'(i_r + 1'b1), (state_r == S_TB_RD) ? left_r : r_r};
  assign addr_b = {i_r, AW'(r_w - coin_w)};
  assign addr_w = {i_r, r_r};
  assign mem_we = (state_r == S_DP_WR);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      fewest_mem[addr_w] <= best;
    end
    rd_a_q <= fewest_mem[addr_a];
    rd_b_q <= fewest_mem[addr_b];
  end

  // Table pass: keep the cheaper of skipping this coin or adding one more of it
  entry_t next_row, alt;

  assign next_row = (i_r == LAST_ROW) ? ((r_r == '0) ? entry_t'(0) : NO_WAY) : rd_a_q;
  assign alt      = {1'b0, rd_b_q[AW-1:0] + AW'(1)};
  assign best     = (coin_fits_r && !rd_b_q[AW] && (alt < next_row)) ? alt : next_row;

  // Pick-back: smallest count of this slot that still reaches the optimum
  entry_t        rest;
  logic [AW:0]   rest_sum;
  logic          tb_match;

  assign rest     = (i_r == LAST_ROW) ? ((left_r == '0) ? entry_t'(0) : NO_WAY) : rd_a_q;
  assign rest_sum = {1'b0, rest[AW-1:0]} + {1'b0, k_r};
  assign tb_match = !rest[AW] && (rest_sum == {1'b0, need_r});

  // Clamp a count to the 10-bit result fields
  function automatic logic [FIELD_W-1:0] sat_field(input logic [AW-1:0] v);
    logic [SAT_W-1:0] w;
    w = SAT_W'(v);
    return (w > SAT_W'(FIELD_MAX)) ? FIELD_MAX : w[FIELD_W-1:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;  // drop the beat once taken
    i_nxt         = i_r;
    r_nxt         = r_r;
    amount_nxt    = amount_r;
    left_nxt      = left_r;
    k_nxt         = k_r;
    need_nxt      = need_r;
    found_nxt     = found_r;
    total_nxt     = total_r;
    cnt_nxt       = cnt_r;
    res_nxt       = res_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          amount_nxt = in_ch.amount;
          i_nxt      = LAST_ROW;
          r_nxt      = '0;
          found_nxt  = 1'b0;
          total_nxt  = '0;
          for (int j = 0; j < REPORT_SLOTS; j++) begin
            cnt_nxt[j] = '0;
          end
          state_nxt  = S_DP_RD;
        end
      end

      S_DP_RD: begin
        state_nxt = S_DP_WR;
      end

      S_DP_WR: begin
        if (r_r == amount_r) begin
          if (i_r == '0) begin
            // best is now the optimum for the whole amount
            if (best[AW]) begin
              state_nxt = S_DONE;
            end else begin
              found_nxt = 1'b1;
              total_nxt = best[AW-1:0];
              need_nxt  = best[AW-1:0];
              left_nxt  = amount_r;
              k_nxt     = '0;
              state_nxt = S_TB_RD;
            end
          end else begin
            i_nxt     = i_r - 1'b1;
            r_nxt     = '0;
            state_nxt = S_DP_RD;
          end
        end else begin
          r_nxt     = r_r + 1'b1;
          state_nxt = S_DP_RD;
        end
      end

      S_TB_RD: begin
        if (cur_coin == '0) begin
          // unused denomination: count stays zero, advance the slot
          if (i_r == LAST_ROW) begin
            state_nxt = S_DONE;
          end else begin
            i_nxt     = i_r + 1'b1;
            k_nxt     = '0;
          end
        end else begin
          state_nxt = S_TB_CHK;
        end
      end

      S_TB_CHK: begin
        if (tb_match || !coin_fits_left) begin
          for (int j = 0; j < REPORT_SLOTS; j++) begin
            if (SLOT_W'(j) == SLOT_W'(i_r)) begin
              cnt_nxt[j] = k_r;
            end
          end
          need_nxt = need_r - k_r;
          if (i_r == LAST_ROW) begin
            state_nxt = S_DONE;
          end else begin
            i_nxt     = i_r + 1'b1;
            k_nxt     = '0;
            state_nxt = S_TB_RD;
          end
        end else begin
          left_nxt  = AW'(left_w - coin_w);
          k_nxt     = k_r + 1'b1;
          state_nxt = S_TB_RD;
        end
      end

      S_DONE: begin
        // hold until the output register is free
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt          = 1'b1;
          res_nxt.solution_found = found_r;
          res_nxt.total_coins    = sat_field(total_r);
          res_nxt.count_first    = sat_field(cnt_r[0]);
          res_nxt.count_second   = sat_field(cnt_r[1]);
          res_nxt.count_third    = sat_field(cnt_r[2]);
          res_nxt.count_fourth   = sat_field(cnt_r[3]);
          res_nxt.count_fifth    = sat_field(cnt_r[4]);
          state_nxt              = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state and configuration registers
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;

  assign cfg_we  = psel && penable && pwrite;
  assign cfg_idx = paddr[CFG_ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      for (int j = 0; j < NUM_CFG_REGS; j++) begin
        coin_r[j] <= COIN_RESET[j];
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_idx)
          REG_COIN_0: coin_r[0] <= pwdata[COIN_W-1:0];
          REG_COIN_1: coin_r[1] <= pwdata[COIN_W-1:0];
          REG_COIN_2: coin_r[2] <= pwdata[COIN_W-1:0];
          REG_COIN_3: coin_r[3] <= pwdata[COIN_W-1:0];
          REG_COIN_4: coin_r[4] <= pwdata[COIN_W-1:0];
          default: ;  // unmapped index: ignore the write
        endcase
      end
    end
  end

  // Datapath registers, no reset needed
  always_ff @(posedge clk) begin
    i_r      <= i_nxt;
    r_r      <= r_nxt;
    amount_r <= amount_nxt;
    left_r   <= left_nxt;
    k_r      <= k_nxt;
    need_r   <= need_nxt;
    found_r  <= found_nxt;
    total_r  <= total_nxt;
    cnt_r    <= cnt_nxt;
    res_r    <= res_nxt;
  end

  // Readback
  always_comb begin
    unique case (cfg_idx)
      REG_COIN_0: prdata = CFG_DATA_W'(coin_r[0]);
      REG_COIN_1: prdata = CFG_DATA_W'(coin_r[1]);
      REG_COIN_2: prdata = CFG_DATA_W'(coin_r[2]);
      REG_COIN_3: prdata = CFG_DATA_W'(coin_r[3]);
      REG_COIN_4: prdata = CFG_DATA_W'(coin_r[4]);
      default:    prdata = '0;
    endcase
  end

  assign pready         = 1'b1;
  assign in_ch.ready    = (state_r == S_IDLE);
  assign out_ch.valid   = out_valid_r;
  assign out_ch.payload = res_r;

`ifndef NO_ASSERTIONS
  a_sweep_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DP_WR) |-> (r_r <= amount_r))
    else $error("table sweep ran past the amount");

  a_pickback_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TB_CHK) |-> (left_r <= amount_r))
    else $error("pick-back remainder exceeds the amount");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_DONE))
    else $error("result beat raised outside the unload state");
`endif

endmodule

// ===== dv/tb_minimum_coin_change_search_unit.sv =====
// Self-checking testbench for minimum_coin_change_search_unit: a driver, a monitor
// and an exact predictor of the fewest-coin answer, over several coin settings.
// Depends on mccs_pkg, mccs_in_if, mccs_out_if and the RTL top level.
module tb_minimum_coin_change_search_unit import mccs_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          NUM_DENOMS  = 5;
  localparam int          AMOUNT_W    = 10;
  localparam int unsigned NO_WAY      = 32'hFFFF_FFFF;
  // Slowest item: a table sweep over every remainder plus the pick-back of every coin;
  // ~110 such items with gaps and stalls stay far below this limit.
  localparam longint      CYCLE_LIMIT = 64'd12_000_000;
  localparam int          LONG_HOLD   = 3000;
  localparam int          TAIL_CYCLES = 64;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  // Configuration port, parked idle from time zero
  logic                  psel    = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr   = '0;
  logic [CFG_DATA_W-1:0] pwdata  = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  mccs_in_if #(.AMOUNT_WIDTH(AMOUNT_W)) in_ch ();
  mccs_out_if                           out_ch ();

  minimum_coin_change_search_unit #(
    .NUM_DENOMINATIONS(NUM_DENOMS),
    .AMOUNT_WIDTH     (AMOUNT_W)
  ) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow of the coin registers, updated on every write to a coin register
  coin_t               coin_cfg [NUM_CFG_REGS];
  // Fewest coins of denominations i..N-1 that make exactly r
  int unsigned         least_coins [NUM_DENOMS+1][1 << AMOUNT_W];

  logic [AMOUNT_W-1:0] amounts_to_send [$];
  mccs_result_t        expected_change [$];

  bit     idling_on;
  bit     rx_hold_request;
  int     rx_hold_left;
  int     rx_gap;
  int     tx_gap;
  int     mismatches;
  int     amounts_queued;
  int     amounts_sent;
  int     results_seen;
  int     no_solution_seen;
  int     settings_used;
  longint cycle_count;

  // Fewest-coin change for one amount under the current coin values. Build the
  // suffix table innermost denomination first, then walk outermost first and take
  // the smallest count that still reaches the optimum: that gives the earliest
  // combination in search order when several share the lowest coin count.
  function automatic mccs_result_t solve_change(input logic [AMOUNT_W-1:0] amount);
    int unsigned  c;
    int unsigned  best;
    int unsigned  k;
    int unsigned  rest;
    int unsigned  remaining;
    int unsigned  need;
    int unsigned  picked [NUM_DENOMS];
    mccs_result_t res;
    res = '0;
    for (int r = 0; r <= amount; r++)
      least_coins[NUM_DENOMS][r] = (r == 0) ? 0 : NO_WAY;
    for (int i = NUM_DENOMS - 1; i >= 0; i--) begin
      c = coin_cfg[i];
      for (int r = 0; r <= amount; r++) begin
        best = least_coins[i+1][r];
        // a zero-valued coin never contributes
        if (c != 0 && r >= c && least_coins[i][r-c] != NO_WAY &&
            least_coins[i][r-c] + 1 < best)
          best = least_coins[i][r-c] + 1;
        least_coins[i][r] = best;
      end
    end
    // no exact change: every field stays zero
    if (least_coins[0][amount] == NO_WAY)
      return res;
    remaining = amount;
    need      = least_coins[0][amount];
    res.solution_found = 1'b1;
    res.total_coins    = FIELD_W'(need);
    for (int i = 0; i < NUM_DENOMS; i++) begin
      c = coin_cfg[i];
      k = 0;
      if (c != 0) begin
        while (k * c <= remaining) begin
          rest = least_coins[i+1][remaining - k * c];
          if (rest != NO_WAY && rest + k == need)
            break;
          k++;
        end
        remaining -= k * c;
      end
      picked[i] = k;
      need -= k;
    end
    res.count_first  = FIELD_W'(picked[0]);
    res.count_second = FIELD_W'(picked[1]);
    res.count_third  = FIELD_W'(picked[2]);
    res.count_fourth = FIELD_W'(picked[3]);
    res.count_fifth  = FIELD_W'(picked[4]);
    return res;
  endfunction

  function automatic void check_field(input string name, input logic [FIELD_W-1:0] want,
                                      input logic [FIELD_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // Mostly small amounts keep the search short; a few span the whole field.
  function automatic logic [AMOUNT_W-1:0] pick_amount();
    if ($urandom_range(0, 6) == 0)
      return AMOUNT_W'($urandom_range(0, (1 << AMOUNT_W) - 1));
    return AMOUNT_W'($urandom_range(0, 63));
  endfunction

  // Coin values: mostly small, sometimes anywhere, sometimes the extremes.
  function automatic coin_t pick_coin();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2, 3:    return COIN_W'($urandom_range(1, (1 << COIN_W) - 1));
      default: return COIN_W'($urandom_range(1, 40));
    endcase
  endfunction

  task automatic queue_amount(input logic [AMOUNT_W-1:0] amount);
    amounts_to_send.push_back(amount);
    amounts_queued++;
  endtask

  // Hold until every queued amount has come back as a result beat.
  task automatic wait_drained();
    while (results_seen != amounts_queued)
      @(posedge clk);
  endtask

  // Setup cycle, then access cycle; the register takes the data at the edge that
  // ends the access cycle. Upper data bits carry noise the block must drop.
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input coin_t value);
    logic [CFG_DATA_W-1:0] word;
    word = $urandom();
    word[COIN_W-1:0] = value;
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= word;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    // writes past the last coin register are dropped by the block
    if (idx < NUM_CFG_REGS)
      coin_cfg[idx] = value;
  endtask

  // Read every coin register back and compare with the shadow copy.
  task automatic verify_coins();
    logic [CFG_DATA_W-1:0] word;
    for (int i = 0; i < NUM_CFG_REGS; i++) begin
      @(posedge clk);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= {REG_COIN_0 + CFG_IDX_W'(i), 2'b00};
      @(posedge clk);
      penable <= 1'b1;
      @(posedge clk);
      word = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      if (word !== CFG_DATA_W'(coin_cfg[i])) begin
        $error("coin_value_%0d: expected %0d, actual %0d", i, coin_cfg[i], word);
        mismatches++;
      end
    end
  endtask

  task automatic set_coins(input coin_t v0, input coin_t v1, input coin_t v2,
                           input coin_t v3, input coin_t v4);
    cfg_write(REG_COIN_0, v0);
    cfg_write(REG_COIN_1, v1);
    cfg_write(REG_COIN_2, v2);
    cfg_write(REG_COIN_3, v3);
    cfg_write(REG_COIN_4, v4);
    verify_coins();
    settings_used++;
  endtask

  // Driver: offer the next pending amount, hold it until taken, then maybe idle
  // for a short burst before the next one.
  always @(posedge clk) begin : tx_side
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_change.push_back(solve_change(in_ch.amount));
        amounts_sent++;
        if (idling_on && $urandom_range(0, 3) == 0)
          tx_gap = $urandom_range(1, 12);
      end
      // a beat still waiting for ready keeps valid and amount as they are
      if (!(in_ch.valid && !in_ch.ready)) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_ch.valid <= 1'b0;
        end else if (amounts_to_send.size() != 0) begin
          in_ch.valid  <= 1'b1;
          in_ch.amount <= amounts_to_send.pop_front();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result beat against the oldest expectation, and throttle
  // ready with short random bursts or one long hold-off on request.
  always @(posedge clk) begin : rx_side
    mccs_result_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (expected_change.size() == 0) begin
          $error("result beat with no amount outstanding");
          mismatches++;
        end else begin
          want = expected_change.pop_front();
          if (!want.solution_found)
            no_solution_seen++;
          check_field("solution_found", FIELD_W'(want.solution_found),
                      FIELD_W'(out_ch.payload.solution_found));
          check_field("total_coins",  want.total_coins,  out_ch.payload.total_coins);
          check_field("count_first",  want.count_first,  out_ch.payload.count_first);
          check_field("count_second", want.count_second, out_ch.payload.count_second);
          check_field("count_third",  want.count_third,  out_ch.payload.count_third);
          check_field("count_fourth", want.count_fourth, out_ch.payload.count_fourth);
          check_field("count_fifth",  want.count_fifth,  out_ch.payload.count_fifth);
        end
      end
      if (rx_hold_request) begin
        rx_hold_left    = LONG_HOLD;
        rx_hold_request = 1'b0;
      end
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        out_ch.ready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if (idling_on && $urandom_range(0, 5) == 0)
          rx_gap = $urandom_range(1, 12);
      end
    end
  end

  // Watchdog: end the run once the cycle limit is reached.
  always @(posedge clk) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, amounts_queued - results_seen);
      $display("status: fail");
      $finish;
    end
  end

  initial begin : stimulus
    logic [CFG_IDX_W-1:0] stray;
    for (int i = 0; i < NUM_CFG_REGS; i++)
      coin_cfg[i] = COIN_RESET[i];
    idling_on    = 1'b1;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset coins: zero amount, single coin, and amounts that toggle every bit
    verify_coins();
    settings_used = 1;
    queue_amount(10'd0);
    queue_amount(10'd1);
    queue_amount(10'd4);
    queue_amount(10'd30);
    queue_amount(10'd99);
    queue_amount(10'd341);
    queue_amount(10'd512);
    queue_amount(10'd682);
    queue_amount(10'd1023);
    wait_drained();

    // Extreme coin values, one of them zero and so never used
    set_coins(10'd1023, 10'd0, 10'd7, 10'd3, 10'd1);
    queue_amount(10'd1023);
    queue_amount(10'd1022);
    queue_amount(10'd10);
    queue_amount(10'd0);
    queue_amount(10'd6);
    wait_drained();

    // All coins even: odd amounts have no exact change
    set_coins(10'd6, 10'd4, 10'd10, 10'd0, 10'd14);
    queue_amount(10'd7);
    queue_amount(10'd1023);
    queue_amount(10'd24);
    queue_amount(10'd0);
    wait_drained();

    // Several combinations share the lowest count: earliest in search order wins
    set_coins(10'd2, 10'd1, 10'd3, 10'd5, 10'd4);
    queue_amount(10'd6);
    queue_amount(10'd8);
    queue_amount(10'd1);
    wait_drained();

    // Write past the last coin register; every coin must read back unchanged
    stray = CFG_IDX_W'($urandom_range(NUM_CFG_REGS, (1 << CFG_IDX_W) - 1));
    cfg_write(stray, pick_coin());
    verify_coins();

    // Random coin settings; each phase stops halfway until all results are back.
    // The second phase starts with a long receiver stall so the block backs up.
    for (int phase = 0; phase < 5; phase++) begin
      idling_on = (phase != 4);
      set_coins(pick_coin(), pick_coin(), pick_coin(), pick_coin(), pick_coin());
      if (phase == 1) begin
        rx_hold_request = 1'b1;
        repeat (8) queue_amount(AMOUNT_W'($urandom_range(0, 15)));
      end
      repeat (8) queue_amount(pick_amount());
      wait_drained();
      repeat (8) queue_amount(pick_amount());
      wait_drained();
    end

    // Let any stray beat show up before closing
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d amounts across %0d coin settings, incl. zero and extreme coins",
             amounts_sent, settings_used);
    $display("checked %0d results, %0d without exact change", results_seen,
             no_solution_seen);
    if (mismatches == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
